// File: design/ipmd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipmd_pkg
// Shared widths, register codes and reset values for the incremental PID
// motor drive.
// ----------------------------------------------------------------------------
package ipmd_pkg;

  // Width of speeds and of the signed drive.
  localparam int VALUE_WIDTH     = 16;
  localparam int GAIN_WIDTH      = 16;
  localparam int DUTY_WIDTH      = 15;
  localparam int CFG_INDEX_WIDTH = 8;
  localparam int CFG_DATA_WIDTH  = 16;

  // Error, first difference and second difference grow by one bit each.
  localparam int ERR_WIDTH = VALUE_WIDTH + 1;
  localparam int D1_WIDTH  = VALUE_WIDTH + 2;
  localparam int D2_WIDTH  = VALUE_WIDTH + 3;
  localparam int P1_WIDTH  = GAIN_WIDTH + D1_WIDTH;
  localparam int PI_WIDTH  = GAIN_WIDTH + ERR_WIDTH;
  localparam int P2_WIDTH  = GAIN_WIDTH + D2_WIDTH;
  // Three products plus the held drive never overflow this width.
  localparam int ACC_WIDTH = P2_WIDTH + 3;

  // Largest positive drive value.
  localparam logic signed [ACC_WIDTH-1:0] VMAX =
    ACC_WIDTH'((64'd1 << (VALUE_WIDTH - 1)) - 64'd1);

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_GAIN_P      = CFG_INDEX_WIDTH'(0),
    REG_GAIN_I      = CFG_INDEX_WIDTH'(1),
    REG_GAIN_D      = CFG_INDEX_WIDTH'(2),
    REG_DRIVE_LIMIT = CFG_INDEX_WIDTH'(3)
  } cfg_reg_t;

  localparam logic signed [GAIN_WIDTH-1:0] GAIN_P_RESET      = GAIN_WIDTH'(5);
  localparam logic signed [GAIN_WIDTH-1:0] GAIN_I_RESET      = GAIN_WIDTH'(0);
  localparam logic signed [GAIN_WIDTH-1:0] GAIN_D_RESET      = GAIN_WIDTH'(2);
  localparam logic        [DUTY_WIDTH-1:0] DRIVE_LIMIT_RESET = DUTY_WIDTH'(10000);

endpackage
`default_nettype wire

// File: design/ipmd_cfg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipmd_cfg_if
// Register write channel: index and data under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ipmd_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [ipmd_pkg::CFG_INDEX_WIDTH-1:0] index;
  logic [ipmd_pkg::CFG_DATA_WIDTH-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: design/ipmd_sample_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipmd_sample_if
// Input sample channel: target and measured speed.
// ----------------------------------------------------------------------------
interface ipmd_sample_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [ipmd_pkg::VALUE_WIDTH-1:0] target_speed;
  logic signed [ipmd_pkg::VALUE_WIDTH-1:0] measured_speed;

  modport source (output valid, output target_speed, output measured_speed,
                  input ready);
  modport sink   (input valid, input target_speed, input measured_speed,
                  output ready);
endinterface
`default_nettype wire

// File: design/ipmd_result_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipmd_result_if
// Result channel: saturated drive and the two bridge duties.
// ----------------------------------------------------------------------------
interface ipmd_result_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [ipmd_pkg::VALUE_WIDTH-1:0] drive;
  logic        [ipmd_pkg::DUTY_WIDTH-1:0]  duty_a;
  logic        [ipmd_pkg::DUTY_WIDTH-1:0]  duty_b;

  modport source (output valid, output drive, output duty_a, output duty_b,
                  input ready);
  modport sink   (input valid, input drive, input duty_a, input duty_b,
                  output ready);
endinterface
`default_nettype wire

// File: design/incremental_pid_motor_drive.sv
`default_nettype none
// ----------------------------------------------------------------------------
// incremental_pid_motor_drive
// Velocity-form PID speed controller with saturation and H-bridge duty split.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Carries
//   -------  ---------  -----------------------------------------------
//   cfg      in         register index and data (gains, duty limit)
//   sample   in         target_speed, measured_speed
//   result   out        drive, duty_a, duty_b
//
// A sample waits in the input register while the multiply and saturating
// add run; its result is then loaded into the result register, from which
// it can transfer out.
// A new sample is taken every cycle while the result side does not stall,
// set by the update of the held drive and error history.
// Reset (rst, synchronous) clears both valid flags, the held drive and the
// error history, and loads the register reset values.
// A stall on result holds the result register and, behind it, the input
// register; sample.ready then drops until the result is taken.
// The cfg channel is always ready.
//
// ----------------------------------------------------------------------------
module incremental_pid_motor_drive (
  input  wire logic     clk,
  input  wire logic     rst,
  ipmd_cfg_if.sink      cfg,
  ipmd_sample_if.sink   sample,
  ipmd_result_if.source result
);

  localparam int VW  = ipmd_pkg::VALUE_WIDTH;
  localparam int GW  = ipmd_pkg::GAIN_WIDTH;
  localparam int DW  = ipmd_pkg::DUTY_WIDTH;
  localparam int EW  = ipmd_pkg::ERR_WIDTH;
  localparam int AW  = ipmd_pkg::ACC_WIDTH;

  // --------------------------------------------------------------------------
  // Configuration registers. Writes to an index past the list are dropped.
  // --------------------------------------------------------------------------
  logic signed [GW-1:0] gain_p;
  logic signed [GW-1:0] gain_i;
  logic signed [GW-1:0] gain_d;
  logic        [DW-1:0] drive_limit;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p      <= ipmd_pkg::GAIN_P_RESET;
      gain_i      <= ipmd_pkg::GAIN_I_RESET;
      gain_d      <= ipmd_pkg::GAIN_D_RESET;
      drive_limit <= ipmd_pkg::DRIVE_LIMIT_RESET;
    end else if (cfg.valid) begin
      unique case (ipmd_pkg::cfg_reg_t'(cfg.index))
        ipmd_pkg::REG_GAIN_P:      gain_p      <= signed'(cfg.data[GW-1:0]);
        ipmd_pkg::REG_GAIN_I:      gain_i      <= signed'(cfg.data[GW-1:0]);
        ipmd_pkg::REG_GAIN_D:      gain_d      <= signed'(cfg.data[GW-1:0]);
        ipmd_pkg::REG_DRIVE_LIMIT: drive_limit <= cfg.data[DW-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Flow control. The input register moves into the result register whenever
  // the result register is empty or its content is being taken.
  // --------------------------------------------------------------------------
  logic s1_valid;
  logic out_valid;
  logic out_load_ok;
  logic s1_advance;

  assign out_load_ok  = !out_valid || result.ready;
  assign s1_advance   = s1_valid && out_load_ok;
  assign sample.ready = !s1_valid || out_load_ok;

  // Input register.
  logic signed [VW-1:0] s1_tgt;
  logic signed [VW-1:0] s1_meas;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s1_tgt  <= sample.target_speed;
      s1_meas <= sample.measured_speed;
    end
  end

  // --------------------------------------------------------------------------
  // Controller state: held drive and the two previous errors.
  // --------------------------------------------------------------------------
  logic signed [VW-1:0] accum_drive;
  logic signed [EW-1:0] prev_error;
  logic signed [EW-1:0] prev_prev_error;

  // --------------------------------------------------------------------------
  // Update datapath. The error and its differences are exact; the three
  // products are summed at a width that cannot overflow, and only the final
  // sum is clipped to the duty limit.
  // --------------------------------------------------------------------------
  logic signed [EW-1:0]                   err;
  logic signed [ipmd_pkg::D1_WIDTH-1:0]   diff1;
  logic signed [ipmd_pkg::D2_WIDTH-1:0]   diff2;
  logic signed [ipmd_pkg::P1_WIDTH-1:0]   prod_p;
  logic signed [ipmd_pkg::PI_WIDTH-1:0]   prod_i;
  logic signed [ipmd_pkg::P2_WIDTH-1:0]   prod_d;
  logic signed [AW-1:0]                   sum;
  logic signed [AW-1:0]                   limit_req;
  logic signed [AW-1:0]                   limit;
  logic signed [AW-1:0]                   sat;
  logic signed [VW-1:0]                   drive_next;
  logic        [DW-1:0]                   duty_a_next;
  logic        [DW-1:0]                   duty_b_next;

  assign err   = EW'(s1_tgt) - EW'(s1_meas);
  assign diff1 = ipmd_pkg::D1_WIDTH'(err) - ipmd_pkg::D1_WIDTH'(prev_error);
  assign diff2 = ipmd_pkg::D2_WIDTH'(err)
               - (ipmd_pkg::D2_WIDTH'(prev_error) <<< 1)
               + ipmd_pkg::D2_WIDTH'(prev_prev_error);

  assign prod_p = ipmd_pkg::P1_WIDTH'(gain_p) * ipmd_pkg::P1_WIDTH'(diff1);
  assign prod_i = ipmd_pkg::PI_WIDTH'(gain_i) * ipmd_pkg::PI_WIDTH'(err);
  assign prod_d = ipmd_pkg::P2_WIDTH'(gain_d) * ipmd_pkg::P2_WIDTH'(diff2);

  assign sum = AW'(accum_drive) + AW'(prod_p) + AW'(prod_i) + AW'(prod_d);

  // The limit never exceeds the largest drive the value width can hold.
  assign limit_req = signed'(AW'(drive_limit));
  assign limit     = (limit_req > ipmd_pkg::VMAX) ? ipmd_pkg::VMAX : limit_req;

  always_comb begin
    priority if (sum > limit) begin
      sat = limit;
    end else if (sum < -limit) begin
      sat = -limit;
    end else begin
      sat = sum;
    end
  end

  // Forward drive goes on channel B, reverse drive as a magnitude on A.
  // A zero drive leaves both channels off.
  always_comb begin
    drive_next = VW'(sat);
    unique if (sat > AW'(0)) begin
      duty_a_next = '0;
      duty_b_next = DW'(sat);
    end else if (sat < AW'(0)) begin
      duty_a_next = DW'(-sat);
      duty_b_next = '0;
    end else begin
      duty_a_next = '0;
      duty_b_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accum_drive     <= '0;
      prev_error      <= '0;
      prev_prev_error <= '0;
    end else if (s1_advance) begin
      accum_drive     <= drive_next;
      prev_error      <= err;
      prev_prev_error <= prev_error;
    end
  end

  // --------------------------------------------------------------------------
  // Result register.
  // --------------------------------------------------------------------------
  logic signed [VW-1:0] out_drive;
  logic        [DW-1:0] out_duty_a;
  logic        [DW-1:0] out_duty_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load_ok) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_drive  <= drive_next;
      out_duty_a <= duty_a_next;
      out_duty_b <= duty_b_next;
    end
  end

  assign result.valid  = out_valid;
  assign result.drive  = out_drive;
  assign result.duty_a = out_duty_a;
  assign result.duty_b = out_duty_b;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------

  // Only one bridge channel is ever driven.
  a_one_channel: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_duty_a == '0) || (out_duty_b == '0))
    else $error("both bridge duties are nonzero");

  // The shown drive is the one held for the next update.
  a_held_drive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_drive == accum_drive) || s1_valid)
    else $error("held drive differs from the last result");

  // A sample that moves on shifts the error history.
  a_history: assert property (@(posedge clk) disable iff (rst)
    s1_advance |=> (prev_error == $past(err))
                && (prev_prev_error == $past(prev_error)))
    else $error("error history did not shift");

  // A sample blocked by a stalled result stays in the input register.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_load_ok) |=> s1_valid && $stable(s1_tgt)
                                   && $stable(s1_meas))
    else $error("stalled sample was lost");

endmodule
`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the incremental PID motor drive. Speed samples
// are fed from a backlog, and a bit-accurate copy of the velocity-form
// update predicts each drive and bridge-duty result. Results are checked in
// order, field by field, while the gains, the duty limit and the handshake
// pressure on both sides change from phase to phase.
// ----------------------------------------------------------------------------
module tb;
  import ipmd_pkg::*;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] tgt;
    logic signed [VALUE_WIDTH-1:0] meas;
  } speed_sample_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] drive;
    logic        [DUTY_WIDTH-1:0]  duty_a;
    logic        [DUTY_WIDTH-1:0]  duty_b;
  } motor_cmd_t;

  // How the gains are chosen for a random phase.
  typedef enum {GAINS_SMALL, GAINS_FULL, GAINS_EXTREME, GAINS_TIGHT} gain_plan_t;

  // Index 4 aliases register 0 in its low bits, so a decoder that ignores
  // the upper index bits would corrupt the proportional gain.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNMAPPED = CFG_INDEX_WIDTH'(4);

  localparam int     RESET_CYCLES  = 10;
  localparam int     SETTLE_CYCLES = 6;
  localparam int     HOLD_CYCLES   = 400;
  localparam int     PHASES        = 8;
  localparam int     PHASE_ITEMS   = 172;
  localparam int     MAX_SHOWN     = 10;
  localparam longint LIMIT_NS      = 64'd5_000_000;
  localparam longint DRIVE_MAX     = (longint'(1) << (VALUE_WIDTH - 1)) - 1;

  logic clk = 1'b0;
  logic rst;

  always #5 clk = ~clk;

  ipmd_cfg_if    cfg_ch ();
  ipmd_sample_if sample_ch ();
  ipmd_result_if result_ch ();

  incremental_pid_motor_drive dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .sample (sample_ch),
    .result (result_ch)
  );

  // Speed samples waiting to be offered, and the commands they are expected
  // to produce, oldest first.
  speed_sample_t speed_backlog[$];
  motor_cmd_t    drive_forecast[$];

  // Traffic shaping. These are only changed on the falling edge, so the
  // clocked processes always see a settled value.
  int   idle_pct    = 0;
  int   stall_pct   = 0;
  logic hold_active = 1'b0;
  int   fail_count  = 0;

  // Shadow copy of the register file and of the controller state. The
  // shadow registers follow every accepted write; the state follows every
  // accepted sample.
  logic signed [GAIN_WIDTH-1:0]  kp_reg     = GAIN_P_RESET;
  logic signed [GAIN_WIDTH-1:0]  ki_reg     = GAIN_I_RESET;
  logic signed [GAIN_WIDTH-1:0]  kd_reg     = GAIN_D_RESET;
  logic        [DUTY_WIDTH-1:0]  duty_limit = DRIVE_LIMIT_RESET;
  logic signed [VALUE_WIDTH-1:0] drive_acc  = '0;
  logic signed [ERR_WIDTH-1:0]   err_last   = '0;
  logic signed [ERR_WIDTH-1:0]   err_prior  = '0;

  // One control sample: the increment is formed at full width, added to
  // the held drive, and only the sum is clamped to the duty limit. The
  // limit itself never exceeds the largest drive the value width can carry.
  function automatic motor_cmd_t pid_update(input logic signed [VALUE_WIDTH-1:0] tgt,
                                            input logic signed [VALUE_WIDTH-1:0] meas);
    longint     err;
    longint     lim;
    longint     sum;
    motor_cmd_t cmd;
    err = longint'(tgt) - longint'(meas);
    lim = longint'(duty_limit);
    if (lim > DRIVE_MAX) begin
      lim = DRIVE_MAX;
    end
    sum = longint'(drive_acc)
        + longint'(kp_reg) * (err - longint'(err_last))
        + longint'(ki_reg) * err
        + longint'(kd_reg) * (err - 2 * longint'(err_last) + longint'(err_prior));
    if (sum > lim) begin
      sum = lim;
    end
    if (sum < -lim) begin
      sum = -lim;
    end
    drive_acc = VALUE_WIDTH'(sum);
    err_prior = err_last;
    err_last  = ERR_WIDTH'(err);
    // Forward drive goes on channel B, reverse drive as a magnitude on A.
    cmd.drive  = VALUE_WIDTH'(sum);
    cmd.duty_a = (sum < 0) ? DUTY_WIDTH'(-sum) : '0;
    cmd.duty_b = (sum > 0) ? DUTY_WIDTH'(sum) : '0;
    return cmd;
  endfunction

  function automatic void queue_speeds(input logic [VALUE_WIDTH-1:0] tgt,
                                       input logic [VALUE_WIDTH-1:0] meas);
    speed_backlog.push_back('{tgt: tgt, meas: meas});
  endfunction

  // A register write is one transfer on the config channel. The shadow is
  // updated at the accepting edge; the block is idle whenever this runs.
  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do begin
      @(posedge clk);
    end while (!(cfg_ch.valid && cfg_ch.ready));
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_GAIN_P:      kp_reg     = val;
      REG_GAIN_I:      ki_reg     = val;
      REG_GAIN_D:      kd_reg     = val;
      REG_DRIVE_LIMIT: duty_limit = val[DUTY_WIDTH-1:0];
      default:         ;
    endcase
  endtask

  // Waits until every queued sample has been offered and taken and every
  // predicted command has come back, then lets the pipeline settle.
  task automatic wait_quiet();
    @(negedge clk);
    while (speed_backlog.size() != 0 || sample_ch.valid || drive_forecast.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic report_mismatch(input string field, input longint want_v,
                                 input longint got_v);
    fail_count++;
    if (fail_count <= MAX_SHOWN) begin
      $display("mismatch on %s: expected %0d, got %0d", field, want_v, got_v);
    end
  endtask

  // Sample driver. A sample stays on the bus until it is taken; only then
  // is the next one drawn from the backlog, or the bus idles by chance. The
  // prediction is made at the edge where the transfer happens.
  always @(posedge clk) begin : sample_drive
    speed_sample_t nxt;
    if (rst) begin
      sample_ch.valid          <= 1'b0;
      sample_ch.target_speed   <= '0;
      sample_ch.measured_speed <= '0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        drive_forecast.push_back(pid_update(sample_ch.target_speed,
                                            sample_ch.measured_speed));
      end
      if (!(sample_ch.valid && !sample_ch.ready)) begin
        if (speed_backlog.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          nxt = speed_backlog.pop_front();
          sample_ch.valid          <= 1'b1;
          sample_ch.target_speed   <= nxt.tgt;
          sample_ch.measured_speed <= nxt.meas;
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver. Ready is drawn fresh every cycle unless a long
  // hold-off is in force, which keeps it low throughout.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= !hold_active && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Result checker: every transfer out is matched against the oldest
  // prediction. A transfer with nothing outstanding is a failure by itself.
  always @(posedge clk) begin : result_check
    motor_cmd_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (drive_forecast.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_SHOWN) begin
          $display("unexpected result: drive %0d with no sample outstanding",
                   result_ch.drive);
        end
      end else begin
        want = drive_forecast.pop_front();
        if (result_ch.drive !== want.drive) begin
          report_mismatch("drive", longint'($signed(want.drive)),
                          longint'(result_ch.drive));
        end
        if (result_ch.duty_a !== want.duty_a) begin
          report_mismatch("duty_a", longint'(want.duty_a), longint'(result_ch.duty_a));
        end
        if (result_ch.duty_b !== want.duty_b) begin
          report_mismatch("duty_b", longint'(want.duty_b), longint'(result_ch.duty_b));
        end
      end
    end
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #(LIMIT_NS);
    $display("tb: FAIL");
    $finish;
  end

  initial begin : stimulus
    int                        setpoint;
    int                        idle;
    int                        stall;
    gain_plan_t                plan;
    logic [CFG_DATA_WIDTH-1:0] gain[3];
    logic [CFG_DATA_WIDTH-1:0] duty;
    speed_sample_t             s;

    // Reset is high from time zero until the reset wait is over; the sample and
    // result handshakes are cleared by their own processes during reset.
    rst          = 1'b1;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    setpoint     = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed part, reset gains. A zero error from rest gives zero drive
    // and both duties off; then the extremes of both speed fields, which
    // drive the sum hard into the limit in both directions, and alternating
    // bit patterns.
    @(negedge clk);
    queue_speeds(16'sd0, 16'sd0);
    queue_speeds(16'sd100, 16'sd0);
    queue_speeds(16'sd100, 16'sd100);
    queue_speeds(16'sh7FFF, 16'sh8000);
    queue_speeds(16'sh8000, 16'sh7FFF);
    queue_speeds(16'sh7FFF, 16'sh7FFF);
    queue_speeds(16'sh8000, 16'sh8000);
    queue_speeds(16'sd1, 16'sd0);
    queue_speeds(16'h5555, 16'hAAAA);
    queue_speeds(16'hAAAA, 16'h5555);
    wait_quiet();

    // Extreme gains with the widest limit. The limit is written with bit 15
    // set, which the register must drop. The write to an unmapped index
    // must leave every register alone. With these gains the increment far
    // exceeds the drive range, so only the clamp keeps the sum in range.
    write_reg(REG_GAIN_P, 16'h8000);
    write_reg(REG_GAIN_I, 16'h7FFF);
    write_reg(REG_GAIN_D, 16'h8000);
    write_reg(REG_DRIVE_LIMIT, 16'hFFFF);
    write_reg(REG_UNMAPPED, 16'h0001);
    @(negedge clk);
    queue_speeds(16'sh7FFF, 16'sh8000);
    queue_speeds(16'sh8000, 16'sh7FFF);
    queue_speeds(16'sh7FFF, 16'sh8000);
    queue_speeds(16'sd0, 16'sd0);
    queue_speeds(16'sh8000, 16'sh7FFF);
    wait_quiet();

    // A zero limit pins the drive and both duties at zero whatever the error.
    write_reg(REG_GAIN_P, 16'h7FFF);
    write_reg(REG_GAIN_I, 16'h7FFF);
    write_reg(REG_DRIVE_LIMIT, 16'h0000);
    @(negedge clk);
    queue_speeds(16'sd1000, 16'sd0);
    queue_speeds(-16'sd1000, 16'sd0);
    queue_speeds(16'sd0, 16'sd0);
    wait_quiet();

    // Random phases. Each one rewrites every register, pokes an unmapped
    // index, and runs under one of four traffic patterns: free flow, a
    // mostly idle sender, a mostly stalling receiver, or both at once.
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0:       begin idle = 0;  stall = 0;  end
        1:       begin idle = 74; stall = 0;  end
        2:       begin idle = 0;  stall = 74; end
        default: begin idle = 36; stall = 36; end
      endcase
      plan = gain_plan_t'((p + p / 4) % 4);

      for (int g = 0; g < 3; g++) begin
        case (plan)
          GAINS_FULL:    gain[g] = CFG_DATA_WIDTH'($urandom);
          GAINS_EXTREME: gain[g] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
          default:       gain[g] = CFG_DATA_WIDTH'(int'($urandom_range(0, 40)) - 20);
        endcase
      end
      case (plan)
        GAINS_SMALL:   duty = CFG_DATA_WIDTH'($urandom_range(2000, 32767));
        GAINS_FULL:    duty = CFG_DATA_WIDTH'($urandom);
        GAINS_EXTREME: duty = $urandom_range(0, 1) ? 16'h7FFF : 16'hFFFF;
        default:       duty = CFG_DATA_WIDTH'($urandom_range(0, 255));
      endcase
      write_reg(REG_GAIN_P, gain[0]);
      write_reg(REG_GAIN_I, gain[1]);
      write_reg(REG_GAIN_D, gain[2]);
      write_reg(REG_DRIVE_LIMIT, duty);
      write_reg(CFG_INDEX_WIDTH'($urandom_range(REG_UNMAPPED, (1 << CFG_INDEX_WIDTH) - 1)),
                CFG_DATA_WIDTH'($urandom));

      @(negedge clk);
      idle_pct  = idle;
      stall_pct = stall;
      // Most samples track a slowly moving setpoint with small measurement
      // noise, so the loop spends time away from the clamp; the rest are
      // raw random speeds that reach every bit of both fields.
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 25) begin
          s.tgt  = VALUE_WIDTH'($urandom);
          s.meas = VALUE_WIDTH'($urandom);
        end else begin
          if ($urandom_range(0, 19) == 0) begin
            setpoint = int'($urandom_range(0, 6000)) - 3000;
          end
          s.tgt  = VALUE_WIDTH'(setpoint);
          s.meas = VALUE_WIDTH'(setpoint + int'($urandom_range(0, 80)) - 40);
        end
        speed_backlog.push_back(s);
      end

      // In the first free-flow phase the receiver refuses results for a
      // long stretch while samples keep coming, so the pipeline fills and
      // the block must stall its input without losing or repeating one.
      if (p == 0) begin
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_active = 1'b0;
      end
      wait_quiet();
    end

    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
design/ipmd_pkg.sv
design/ipmd_cfg_if.sv
design/ipmd_sample_if.sv
design/ipmd_result_if.sv
design/incremental_pid_motor_drive.sv
verif/tb.sv
